// File: sv/kcl_pkg.sv
// Shared constants, codes and types for the k-means cluster engine.
package kcl_pkg;

	localparam int KCL_MAX_POINT_COUNT   = 1024;
	localparam int KCL_MAX_DIMENSIONS    = 8;
	localparam int KCL_MAX_CLUSTER_COUNT = 16;

	localparam int COORD_W    = 16;
	localparam int MODE_W     = 3;
	localparam int ENTRY_W    = 10;
	localparam int DIMIDX_W   = 3;
	localparam int PC_W       = 11;
	localparam int CC_W       = 5;
	localparam int DC_W       = 4;
	localparam int IL_W       = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_LOAD_POINT  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_CENT   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RUN         = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ_ASSIGN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ_CENT   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd3;

	typedef struct packed {
		logic clr_sums;
		logic dist_v;
		logic dist_first;
		logic acc_en;
		logic cent_we;
	} kcl_ctl_t;

endpackage

// File: sv/kcl_if.sv
// Channel interfaces: item input, result output and configuration write.
interface kcl_in_if import kcl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic [ENTRY_W-1:0]         entry_index;
	logic [DIMIDX_W-1:0]        dim_index;
	logic signed [COORD_W-1:0]  coord_value;
	modport source (output valid, mode, entry_index, dim_index, coord_value, input ready);
	modport sink (input valid, mode, entry_index, dim_index, coord_value, output ready);
endinterface

interface kcl_out_if import kcl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  data_value;
	logic                       index_error;
	modport source (output valid, data_value, index_error, input ready);
	modport sink (input valid, data_value, index_error, output ready);
endinterface

interface kcl_cfg_if import kcl_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/kcl_cell.sv
// One cluster cell: centroid, distance pipeline, min-search link and running sums.
module kcl_cell import kcl_pkg::*; #(
	parameter int IDX               = 0,
	parameter int MAX_POINT_COUNT   = KCL_MAX_POINT_COUNT,
	parameter int MAX_DIMENSIONS    = KCL_MAX_DIMENSIONS,
	parameter int MAX_CLUSTER_COUNT = KCL_MAX_CLUSTER_COUNT,
	localparam int DIM_W  = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1,
	localparam int CI_W   = $clog2(MAX_CLUSTER_COUNT),
	localparam int NC_W   = $clog2(MAX_CLUSTER_COUNT + 1),
	localparam int SUM_W  = COORD_W + $clog2(MAX_POINT_COUNT) + 1,
	localparam int SZ_W   = $clog2(MAX_POINT_COUNT + 1),
	localparam int DIST_W = 2 * COORD_W + $clog2(MAX_DIMENSIONS)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  kcl_ctl_t                                 ctl,
	input  logic [NC_W-1:0]                          nc,
	input  logic [DIM_W-1:0]                         dim,
	input  logic signed [COORD_W-1:0]                coord,
	input  logic [CI_W-1:0]                          win,
	input  logic [MAX_DIMENSIONS-1:0][COORD_W-1:0]   pbuf,
	input  logic [CI_W-1:0]                          wr_cell,
	input  logic signed [COORD_W-1:0]                wr_data,
	input  logic                                     prev_v,
	input  logic [DIST_W-1:0]                        prev_dist,
	input  logic [CI_W-1:0]                          prev_idx,
	output logic                                     next_v,
	output logic [DIST_W-1:0]                        next_dist,
	output logic [CI_W-1:0]                          next_idx,
	output logic signed [COORD_W-1:0]                cent_rd,
	output logic signed [SUM_W-1:0]                  sum_rd,
	output logic [SZ_W-1:0]                          size_rd
);

	logic signed [COORD_W-1:0] cent_q [MAX_DIMENSIONS];
	logic signed [SUM_W-1:0]   sum_q [MAX_DIMENSIONS];
	logic [SZ_W-1:0]           size_q;
	logic signed [COORD_W:0]   diff_s1;
	logic signed [2*COORD_W-1:0] diff_x;
	logic [2*COORD_W-1:0]      sq_s2;
	logic [DIST_W-1:0]         acc_q;
	logic                      v_s1, v_s2, first_s1, first_s2;
	logic                      next_v_q;
	logic [DIST_W-1:0]         next_dist_q;
	logic [CI_W-1:0]           next_idx_q;
	logic                      take;

	assign cent_rd = cent_q[dim];
	assign sum_rd  = sum_q[dim];
	assign size_rd = size_q;
	assign diff_x  = (2*COORD_W)'(diff_s1);

	assign take = (IDX == 0) || ((NC_W'(IDX) < nc) && (acc_q < prev_dist));

	always_ff @(posedge clk) begin
		if (ctl.cent_we && wr_cell == CI_W'(IDX))
			cent_q[dim] <= wr_data;
		if (ctl.clr_sums) begin
			size_q <= '0;
			for (int d = 0; d < MAX_DIMENSIONS; d++)
				sum_q[d] <= '0;
		end else if (ctl.acc_en && win == CI_W'(IDX)) begin
			size_q <= size_q + SZ_W'(1);
			for (int d = 0; d < MAX_DIMENSIONS; d++)
				sum_q[d] <= sum_q[d] + SUM_W'($signed(pbuf[d]));
		end
		diff_s1 <= {coord[COORD_W-1], coord} - {cent_q[dim][COORD_W-1], cent_q[dim]};
		sq_s2   <= diff_x * diff_x;
		if (v_s2)
			acc_q <= (first_s2 ? '0 : acc_q) + DIST_W'(sq_s2);
		next_dist_q <= take ? acc_q : prev_dist;
		next_idx_q  <= take ? CI_W'(IDX) : prev_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			first_s1 <= 1'b0;
			first_s2 <= 1'b0;
			next_v_q <= 1'b0;
		end else begin
			v_s1     <= ctl.dist_v;
			v_s2     <= v_s1;
			first_s1 <= ctl.dist_first;
			first_s2 <= first_s1;
			next_v_q <= prev_v;
		end
	end

	assign next_v    = next_v_q;
	assign next_dist = next_dist_q;
	assign next_idx  = next_idx_q;

endmodule

// File: sv/kcl_div.sv
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
module kcl_div import kcl_pkg::*; #(
	parameter int NUM_W = 27,
	parameter int DEN_W = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_W-1:0]    num,
	input  logic [DEN_W-1:0]           den,
	output logic                       done,
	output logic signed [COORD_W-1:0]  quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] mag_q;
	logic [DEN_W:0]   rem_q;
	logic             neg_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			neg_q <= num[NUM_W-1];
		end else if (cnt_q != '0) begin
			mag_q <= {mag_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial - {1'b0, den} : trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start)
				cnt_q <= CNT_W'(NUM_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(mag_q[COORD_W-1:0]) : $signed(mag_q[COORD_W-1:0]);

endmodule

// File: sv/kmeans_cluster_engine_unit.sv
// Lloyd k-means engine: a row of cluster cells, point memory, shared divider and sequencer.
// Load, read and unused-mode items pass through a finishing state that registers the result.
// A run does, per iteration, an assignment pass over all points (one point memory read per
// coordinate, then the best-distance token walks the whole cell row) and then an update
// pass that divides each coordinate of every non-empty cluster with the one-bit-per-cycle
// divider; a run ends early once an iteration leaves all centroids unchanged.
// No item is accepted while a run is in flight.
module kmeans_cluster_engine_unit import kcl_pkg::*; #(
	parameter int MAX_POINT_COUNT   = KCL_MAX_POINT_COUNT,
	parameter int MAX_DIMENSIONS    = KCL_MAX_DIMENSIONS,
	parameter int MAX_CLUSTER_COUNT = KCL_MAX_CLUSTER_COUNT
) (
	input logic        clk,
	input logic        arst_n,
	kcl_in_if.sink     in_ch,
	kcl_out_if.source  out_ch,
	kcl_cfg_if.sink    cfg
);

	localparam int DIM_W    = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
	localparam int ND_W     = $clog2(MAX_DIMENSIONS + 1);
	localparam int CI_W     = $clog2(MAX_CLUSTER_COUNT);
	localparam int NC_W     = $clog2(MAX_CLUSTER_COUNT + 1);
	localparam int PT_AW    = $clog2(MAX_POINT_COUNT);
	localparam int NP_W     = $clog2(MAX_POINT_COUNT + 1);
	localparam int PM_DEPTH = MAX_POINT_COUNT * MAX_DIMENSIONS;
	localparam int ADDR_W   = $clog2(PM_DEPTH);
	localparam int SUM_W    = COORD_W + PT_AW + 1;
	localparam int SZ_W     = NP_W;
	localparam int DIST_W   = 2 * COORD_W + $clog2(MAX_DIMENSIONS);
	localparam logic [2:0] PIPE_LAT = 3'd3;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_FIN   = 9'b000000010,
		S_ITER  = 9'b000000100,
		S_PRD   = 9'b000001000,
		S_PWAIT = 9'b000010000,
		S_CHAIN = 9'b000100000,
		S_UPD   = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_NEXT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [PC_W-1:0] pc_q;
	logic [CC_W-1:0] cc_q;
	logic [DC_W-1:0] dc_q;
	logic [IL_W-1:0] il_q;
	logic [NP_W-1:0] np;
	logic [NC_W-1:0] nc;
	logic [ND_W-1:0] nd;
	logic [DIM_W-1:0] d_last;

	logic [MODE_W-1:0]         mode_q;
	logic [ENTRY_W-1:0]        entry_q;
	logic [DIMIDX_W-1:0]       dim_q;
	logic signed [COORD_W-1:0] coord_q;

	logic [IL_W-1:0]   it_q;
	logic [NP_W-1:0]   p_q;
	logic [NP_W-1:0]   mark_q;
	logic [ADDR_W-1:0] base_q;
	logic [DIM_W-1:0]  d_q;
	logic [NC_W-1:0]   c_q;
	logic [2:0]        wait_q;
	logic              changed_q;
	logic              rd_v_s1;
	logic [DIM_W-1:0]  rd_dim_s1;

	logic                      out_v_q;
	logic signed [COORD_W-1:0] out_data_q;
	logic                      out_err_q;

	logic signed [COORD_W-1:0] pm [PM_DEPTH];
	logic signed [COORD_W-1:0] pm_q;
	logic [ADDR_W-1:0]         pm_raddr, pm_waddr;
	logic                      pm_we;
	logic [CI_W-1:0]           am [MAX_POINT_COUNT];
	logic [CI_W-1:0]           am_q;
	logic [PT_AW-1:0]          am_raddr;

	logic [MAX_DIMENSIONS-1:0][COORD_W-1:0] pbuf_q;

	kcl_ctl_t                  ctl;
	logic [DIM_W-1:0]          cell_dim;
	logic [CI_W-1:0]           sel_c, wr_cell;
	logic signed [COORD_W-1:0] wr_data;
	logic                      ch_v [MAX_CLUSTER_COUNT+1];
	logic [DIST_W-1:0]         ch_dist [MAX_CLUSTER_COUNT+1];
	logic [CI_W-1:0]           ch_idx [MAX_CLUSTER_COUNT+1];
	logic signed [COORD_W-1:0] cent_rd [MAX_CLUSTER_COUNT];
	logic signed [SUM_W-1:0]   sum_rd [MAX_CLUSTER_COUNT];
	logic [SZ_W-1:0]           size_rd [MAX_CLUSTER_COUNT];
	logic signed [COORD_W-1:0] cent_sel;
	logic signed [SUM_W-1:0]   sum_sel;
	logic [SZ_W-1:0]           size_sel;
	logic                      chain_v;

	logic                      div_start, div_done;
	logic signed [COORD_W-1:0] quo;

	logic                      in_fire, upd_active, c_in_use;
	logic                      fin_err;
	logic signed [COORD_W-1:0] fin_data;

	// in-use counts, saturated into range
	always_comb begin
		if (pc_q == '0)
			np = NP_W'(1);
		else if (32'(pc_q) > 32'(MAX_POINT_COUNT))
			np = NP_W'(MAX_POINT_COUNT);
		else
			np = NP_W'(pc_q);
		if (cc_q == '0)
			nc = NC_W'(1);
		else if (32'(cc_q) > 32'(MAX_CLUSTER_COUNT))
			nc = NC_W'(MAX_CLUSTER_COUNT);
		else
			nc = NC_W'(cc_q);
		if (dc_q == '0)
			nd = ND_W'(1);
		else if (32'(dc_q) > 32'(MAX_DIMENSIONS))
			nd = ND_W'(MAX_DIMENSIONS);
		else
			nd = ND_W'(dc_q);
	end
	assign d_last = DIM_W'(nd - ND_W'(1));

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_W'(1);
			cc_q <= CC_W'(1);
			dc_q <= DC_W'(1);
			il_q <= IL_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_POINT_COUNT:     pc_q <= cfg.data[PC_W-1:0];
				CFG_CLUSTER_COUNT:   cc_q <= cfg.data[CC_W-1:0];
				CFG_DIMENSION_COUNT: dc_q <= cfg.data[DC_W-1:0];
				CFG_ITERATION_LIMIT: il_q <= cfg.data[IL_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == S_IDLE) && (!out_v_q || out_ch.ready);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign upd_active  = (state_q == S_UPD) || (state_q == S_DIV);
	assign c_in_use    = 32'(c_q) < 32'(nc);

	// result of a load, read or finished run
	always_comb begin
		fin_err  = 1'b0;
		fin_data = '0;
		case (mode_q)
			MODE_LOAD_POINT:
				fin_err = (32'(entry_q) >= 32'(np)) || (32'(dim_q) >= 32'(nd));
			MODE_LOAD_CENT:
				fin_err = (32'(entry_q) >= 32'(nc)) || (32'(dim_q) >= 32'(nd));
			MODE_READ_ASSIGN: begin
				fin_err = 32'(entry_q) >= 32'(np);
				if (!fin_err && 32'(entry_q) < 32'(mark_q))
					fin_data = COORD_W'(am_q);
			end
			MODE_READ_CENT: begin
				fin_err = (32'(entry_q) >= 32'(nc)) || (32'(dim_q) >= 32'(nd));
				if (!fin_err)
					fin_data = cent_sel;
			end
			default: ;
		endcase
	end

	// point and assignment memories
	assign pm_we    = (state_q == S_FIN) && (mode_q == MODE_LOAD_POINT) && !fin_err;
	assign pm_waddr = ADDR_W'(32'(entry_q) * 32'(MAX_DIMENSIONS) + 32'(dim_q));
	assign pm_raddr = base_q + ADDR_W'(32'(d_q));
	assign am_raddr = PT_AW'(32'(in_ch.entry_index));

	always_ff @(posedge clk) begin
		if (pm_we)
			pm[pm_waddr] <= coord_q;
		pm_q <= pm[pm_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_en)
			am[p_q[PT_AW-1:0]] <= ch_idx[MAX_CLUSTER_COUNT];
		am_q <= am[am_raddr];
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1)
			pbuf_q[rd_dim_s1] <= pm_q;
	end

	// cell row
	assign chain_v  = ch_v[MAX_CLUSTER_COUNT];
	assign sel_c    = upd_active ? c_q[CI_W-1:0] : entry_q[CI_W-1:0];
	assign cent_sel = cent_rd[sel_c];
	assign sum_sel  = sum_rd[sel_c];
	assign size_sel = size_rd[sel_c];
	assign wr_cell  = sel_c;
	assign wr_data  = (state_q == S_DIV) ? quo : coord_q;

	always_comb begin
		if (rd_v_s1)
			cell_dim = rd_dim_s1;
		else if (upd_active)
			cell_dim = d_q;
		else
			cell_dim = DIM_W'(32'(dim_q));
	end

	always_comb begin
		ctl.clr_sums   = state_q == S_ITER;
		ctl.dist_v     = rd_v_s1;
		ctl.dist_first = rd_dim_s1 == '0;
		ctl.acc_en     = (state_q == S_CHAIN) && chain_v;
		ctl.cent_we    = ((state_q == S_FIN) && (mode_q == MODE_LOAD_CENT) && !fin_err)
		              || ((state_q == S_DIV) && div_done && (quo != cent_sel));
	end

	assign ch_v[0]    = (state_q == S_PWAIT) && (wait_q == PIPE_LAT);
	assign ch_dist[0] = '0;
	assign ch_idx[0]  = '0;

	for (genvar c = 0; c < MAX_CLUSTER_COUNT; c++) begin : g_cell
		kcl_cell #(
			.IDX               (c),
			.MAX_POINT_COUNT   (MAX_POINT_COUNT),
			.MAX_DIMENSIONS    (MAX_DIMENSIONS),
			.MAX_CLUSTER_COUNT (MAX_CLUSTER_COUNT)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.nc        (nc),
			.dim       (cell_dim),
			.coord     (pm_q),
			.win       (ch_idx[MAX_CLUSTER_COUNT]),
			.pbuf      (pbuf_q),
			.wr_cell   (wr_cell),
			.wr_data   (wr_data),
			.prev_v    (ch_v[c]),
			.prev_dist (ch_dist[c]),
			.prev_idx  (ch_idx[c]),
			.next_v    (ch_v[c+1]),
			.next_dist (ch_dist[c+1]),
			.next_idx  (ch_idx[c+1]),
			.cent_rd   (cent_rd[c]),
			.sum_rd    (sum_rd[c]),
			.size_rd   (size_rd[c])
		);
	end

	assign div_start = (state_q == S_UPD) && c_in_use && (size_sel != '0);

	kcl_div #(
		.NUM_W (SUM_W),
		.DEN_W (SZ_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_sel),
		.den    (size_sel),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= in_ch.mode;
			entry_q <= in_ch.entry_index;
			dim_q   <= in_ch.dim_index;
			coord_q <= in_ch.coord_value;
		end
		rd_dim_s1 <= d_q;
		if (state_q == S_FIN) begin
			out_data_q <= fin_data;
			out_err_q  <= fin_err;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_v_q   <= 1'b0;
			it_q      <= '0;
			p_q       <= '0;
			mark_q    <= '0;
			base_q    <= '0;
			d_q       <= '0;
			c_q       <= '0;
			wait_q    <= '0;
			changed_q <= 1'b0;
			rd_v_s1   <= 1'b0;
		end else begin
			rd_v_s1 <= state_q == S_PRD;
			if (state_q == S_FIN)
				out_v_q <= 1'b1;
			else if (out_ch.ready)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						it_q <= '0;
						if (in_ch.mode == MODE_RUN && il_q != '0)
							state_q <= S_ITER;
						else
							state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				S_ITER: begin
					p_q       <= '0;
					base_q    <= '0;
					d_q       <= '0;
					changed_q <= 1'b0;
					if (np > mark_q)
						mark_q <= np;
					state_q <= S_PRD;
				end
				S_PRD: begin
					if (d_q == d_last) begin
						d_q     <= '0;
						wait_q  <= '0;
						state_q <= S_PWAIT;
					end else begin
						d_q <= d_q + DIM_W'(1);
					end
				end
				S_PWAIT: begin
					if (wait_q == PIPE_LAT)
						state_q <= S_CHAIN;
					else
						wait_q <= wait_q + 3'd1;
				end
				S_CHAIN: begin
					if (chain_v) begin
						if (p_q == np - NP_W'(1)) begin
							c_q     <= '0;
							d_q     <= '0;
							state_q <= S_UPD;
						end else begin
							p_q     <= p_q + NP_W'(1);
							base_q  <= base_q + ADDR_W'(MAX_DIMENSIONS);
							state_q <= S_PRD;
						end
					end
				end
				S_UPD: begin
					if (!c_in_use)
						state_q <= S_NEXT;
					else if (size_sel == '0) begin
						c_q <= c_q + NC_W'(1);
						d_q <= '0;
					end else
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (quo != cent_sel)
							changed_q <= 1'b1;
						if (d_q == d_last) begin
							c_q <= c_q + NC_W'(1);
							d_q <= '0;
						end else begin
							d_q <= d_q + DIM_W'(1);
						end
						state_q <= S_UPD;
					end
				end
				S_NEXT: begin
					if (changed_q && (32'(it_q) + 32'd1 < 32'(il_q))) begin
						it_q    <= it_q + IL_W'(1);
						state_q <= S_ITER;
					end else begin
						state_q <= S_FIN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.data_value  = out_data_q;
	assign out_ch.index_error = out_err_q;

	a_div_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the update phase");

	a_chain_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v |-> state_q == S_CHAIN)
		else $error("best-distance token left the row outside the search phase");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_FIN))
		else $error("result raised without a finishing transaction");

	a_mark_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |=> (mark_q >= np))
		else $error("assignment fill mark behind point count after iteration start");

endmodule

// File: tb/kmeans_cluster_engine_unit_checker.sv
// Checker for the k-means engine: follows every channel, predicts each result and compares.
`timescale 1ns / 1ps
module kmeans_cluster_engine_unit_checker import kcl_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	kcl_in_if    in_ch,
	kcl_out_if   out_ch,
	kcl_cfg_if   cfg,
	output int   fails,
	output int   pending
);
	typedef struct {
		logic signed [COORD_W-1:0] data_value;
		logic                      index_error;
	} reply_t;

	logic signed [COORD_W-1:0] points [KCL_MAX_POINT_COUNT*KCL_MAX_DIMENSIONS];
	logic signed [COORD_W-1:0] centroids [KCL_MAX_CLUSTER_COUNT*KCL_MAX_DIMENSIONS];
	logic [3:0]                labels [KCL_MAX_POINT_COUNT];
	logic [PC_W-1:0]           point_cnt;
	logic [CC_W-1:0]           cluster_cnt;
	logic [DC_W-1:0]           dim_cnt;
	logic [IL_W-1:0]           iter_lim;
	reply_t                    replies_due [$];

	function automatic int clamp(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void run_lloyd(int np, int nc, int nd);
		longint sums [KCL_MAX_CLUSTER_COUNT][KCL_MAX_DIMENSIONS];
		int     sizes [KCL_MAX_CLUSTER_COUNT];
		longint best_dist, cand_dist, diff, q;
		int     best;
		bit     moved;
		for (int it = 0; it < int'(iter_lim); it++) begin
			moved = 0;
			for (int c = 0; c < KCL_MAX_CLUSTER_COUNT; c++) begin
				sizes[c] = 0;
				for (int d = 0; d < KCL_MAX_DIMENSIONS; d++) sums[c][d] = 0;
			end
			for (int p = 0; p < np; p++) begin
				best = 0;
				best_dist = -1;
				for (int c = 0; c < nc; c++) begin
					cand_dist = 0;
					for (int d = 0; d < nd; d++) begin
						diff = longint'(points[p*KCL_MAX_DIMENSIONS+d])
							- longint'(centroids[c*KCL_MAX_DIMENSIONS+d]);
						cand_dist += diff * diff;
					end
					if (best_dist < 0 || cand_dist < best_dist) begin
						best_dist = cand_dist;
						best = c;
					end
				end
				labels[p] = best[3:0];
				sizes[best]++;
				for (int d = 0; d < nd; d++)
					sums[best][d] += longint'(points[p*KCL_MAX_DIMENSIONS+d]);
			end
			for (int c = 0; c < nc; c++) begin
				if (sizes[c] == 0) continue;
				for (int d = 0; d < nd; d++) begin
					q = sums[c][d] / sizes[c];
					if (q[15:0] != centroids[c*KCL_MAX_DIMENSIONS+d]) begin
						moved = 1;
						centroids[c*KCL_MAX_DIMENSIONS+d] = q[15:0];
					end
				end
			end
			if (!moved) break;
		end
	endfunction

	function automatic reply_t apply_item(logic [MODE_W-1:0] mode, int entry, int dim,
			logic signed [COORD_W-1:0] coord);
		reply_t r;
		int np, nc, nd;
		np = clamp(int'(point_cnt), KCL_MAX_POINT_COUNT);
		nc = clamp(int'(cluster_cnt), KCL_MAX_CLUSTER_COUNT);
		nd = clamp(int'(dim_cnt), KCL_MAX_DIMENSIONS);
		r.data_value = '0;
		r.index_error = 0;
		case (mode)
			MODE_LOAD_POINT: begin
				if (entry >= np || dim >= nd) r.index_error = 1;
				else points[entry*KCL_MAX_DIMENSIONS+dim] = coord;
			end
			MODE_LOAD_CENT: begin
				if (entry >= nc || dim >= nd) r.index_error = 1;
				else centroids[entry*KCL_MAX_DIMENSIONS+dim] = coord;
			end
			MODE_RUN: run_lloyd(np, nc, nd);
			MODE_READ_ASSIGN: begin
				if (entry >= np) r.index_error = 1;
				else r.data_value = {12'd0, labels[entry]};
			end
			MODE_READ_CENT: begin
				if (entry >= nc || dim >= nd) r.index_error = 1;
				else r.data_value = centroids[entry*KCL_MAX_DIMENSIONS+dim];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
		point_cnt = 1;
		cluster_cnt = 1;
		dim_cnt = 1;
		iter_lim = 1;
		foreach (labels[i]) labels[i] = '0;
		foreach (points[i]) points[i] = '0;
		foreach (centroids[i]) centroids[i] = '0;
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (replies_due.size() == 0) begin
					report("unexpected transaction, data_value", out_ch.data_value, 0);
				end else begin
					want = replies_due.pop_front();
					if (out_ch.data_value !== want.data_value)
						report("data_value", out_ch.data_value, want.data_value);
					if (out_ch.index_error !== want.index_error)
						report("index_error", out_ch.index_error, want.index_error);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_POINT_COUNT:     point_cnt = cfg.data[PC_W-1:0];
					CFG_CLUSTER_COUNT:   cluster_cnt = cfg.data[CC_W-1:0];
					CFG_DIMENSION_COUNT: dim_cnt = cfg.data[DC_W-1:0];
					CFG_ITERATION_LIMIT: iter_lim = cfg.data[IL_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				replies_due.push_back(apply_item(in_ch.mode, int'(in_ch.entry_index),
					int'(in_ch.dim_index), in_ch.coord_value));
			pending = replies_due.size();
		end
	end
endmodule

// File: tb/kmeans_cluster_engine_unit_tb.sv
// Testbench top for the k-means engine: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module kmeans_cluster_engine_unit_tb;
	import kcl_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   sent;
	bit   quiet;
	bit   hold_req;

	kcl_in_if  in_ch ();
	kcl_out_if out_ch ();
	kcl_cfg_if cfg ();

	kmeans_cluster_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	kmeans_cluster_engine_unit_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.cfg     (cfg),
		.fails   (fails),
		.pending (pending)
	);

	initial clk = 0;
	always #10 clk = ~clk;

	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int burst;
		out_ch.ready = 0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 0;
				for (int n = 0; n < 300; n++) @(negedge clk);
				hold_req = 0;
			end
			if (burst > 0) begin
				burst--;
				out_ch.ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 2);
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
			end
		end
	end

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return COORD_W'($signed($urandom_range(0, 6)) - 3);
			5, 6, 7:       return COORD_W'($signed($urandom_range(0, 4000)) - 2000);
			default:       return COORD_W'($urandom());
		endcase
	endfunction

	task automatic send_item(logic [MODE_W-1:0] mode, int entry, int dim,
			logic signed [COORD_W-1:0] coord);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.mode <= mode;
		in_ch.entry_index <= ENTRY_W'(entry);
		in_ch.dim_index <= DIMIDX_W'(dim);
		in_ch.coord_value <= coord;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		drain();
		repeat (4) @(negedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic run_phase(int pc, int cc, int dc, int il, bit may_run, int nrand);
		int np, nc, nd, r;
		logic [MODE_W-1:0] m;
		write_reg(CFG_POINT_COUNT, pc);
		write_reg(CFG_CLUSTER_COUNT, cc);
		write_reg(CFG_DIMENSION_COUNT, dc);
		write_reg(CFG_ITERATION_LIMIT, il);
		np = pc < 1 ? 1 : (pc > KCL_MAX_POINT_COUNT ? KCL_MAX_POINT_COUNT : pc);
		nc = cc < 1 ? 1 : (cc > KCL_MAX_CLUSTER_COUNT ? KCL_MAX_CLUSTER_COUNT : cc);
		nd = dc < 1 ? 1 : (dc > KCL_MAX_DIMENSIONS ? KCL_MAX_DIMENSIONS : dc);
		if (may_run)
			for (int p = 0; p < np; p++)
				for (int d = 0; d < nd; d++) send_item(MODE_LOAD_POINT, p, d, rand_coord());
		for (int c = 0; c < nc; c++)
			for (int d = 0; d < nd; d++) send_item(MODE_LOAD_CENT, c, d, rand_coord());
		for (int i = 0; i < nrand; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				send_item(MODE_LOAD_POINT, $urandom_range(0, np - 1),
					$urandom_range(0, nd - 1), rand_coord());
			else if (r < 42)
				send_item(MODE_LOAD_CENT, $urandom_range(0, nc - 1),
					$urandom_range(0, nd - 1), rand_coord());
			else if (r < 60)
				send_item(MODE_READ_ASSIGN, $urandom_range(0, np - 1), $urandom(), 0);
			else if (r < 78 || (r < 84 && !may_run))
				send_item(MODE_READ_CENT, $urandom_range(0, nc - 1),
					$urandom_range(0, nd - 1), COORD_W'($urandom()));
			else if (r < 84)
				send_item(MODE_RUN, $urandom(), $urandom(), COORD_W'($urandom()));
			else begin
				m = MODE_W'($urandom());
				if (m == MODE_RUN && !may_run) m = MODE_READ_ASSIGN;
				send_item(m, $urandom(), $urandom(), COORD_W'($urandom()));
			end
		end
	endtask

	initial begin
		int ph, pc, dc;
		arst_n = 0;
		quiet = 0;
		hold_req = 0;
		sent = 0;
		in_ch.valid = 0;
		in_ch.mode = MODE_LOAD_POINT;
		in_ch.entry_index = '0;
		in_ch.dim_index = '0;
		in_ch.coord_value = '0;
		cfg.valid = 0;
		cfg.index = CFG_POINT_COUNT;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_item(MODE_READ_ASSIGN, 0, 0, 0);
		send_item(MODE_LOAD_POINT, 0, 0, 16'sh7FFF);
		send_item(MODE_LOAD_CENT, 0, 0, 16'sh8000);
		send_item(MODE_READ_CENT, 0, 0, 0);
		send_item(MODE_RUN, 0, 0, 0);
		send_item(MODE_READ_ASSIGN, 0, 7, 0);
		send_item(MODE_READ_CENT, 0, 0, 0);
		send_item(MODE_LOAD_POINT, 1023, 7, 16'sh1234);
		send_item(MODE_LOAD_POINT, 0, 7, 16'sh1234);
		send_item(MODE_LOAD_CENT, 1, 0, 16'sh4321);
		send_item(MODE_READ_CENT, 0, 7, 0);
		send_item(MODE_READ_CENT, 1023, 0, 0);
		send_item(MODE_READ_ASSIGN, 1023, 0, 0);
		for (int m = MODE_READ_CENT + 1; m < 8; m++)
			send_item(MODE_W'(m), 1023, 7, 16'shFFFF);
		send_item(MODE_LOAD_POINT, 0, 0, 16'sh8000);
		send_item(MODE_LOAD_CENT, 0, 0, 16'sh7FFF);
		send_item(MODE_RUN, 1023, 7, 16'shFFFF);
		send_item(MODE_READ_CENT, 0, 0, 0);
		write_reg(CFG_ITERATION_LIMIT, 0);
		send_item(MODE_LOAD_CENT, 0, 0, 16'sh0100);
		send_item(MODE_RUN, 0, 0, 0);
		send_item(MODE_READ_CENT, 0, 0, 0);

		ph = 0;
		while (sent < 1950) begin
			if (sent > 1650) quiet = 1;
			case (ph)
				0: run_phase(KCL_MAX_POINT_COUNT, KCL_MAX_CLUSTER_COUNT,
					KCL_MAX_DIMENSIONS, 65535, 0, 40);
				1: run_phase(0, 0, 0, 0, 1, 30);
				2: run_phase(2047, 31, 15, 3, 0, 40);
				3: run_phase(8, KCL_MAX_CLUSTER_COUNT, KCL_MAX_DIMENSIONS, 65535, 1, 30);
				4: begin
					hold_req = 1;
					run_phase(12, 3, 2, 4, 1, 60);
				end
				5: begin
					run_phase(10, 4, 3, 5, 1, 20);
					drain();
					run_phase(10, 4, 3, 5, 1, 20);
				end
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						pc = $urandom_range(25, 200);
						dc = $urandom_range(1, 2);
					end else begin
						pc = $urandom_range(1, 24);
						dc = $urandom_range(1, KCL_MAX_DIMENSIONS);
					end
					run_phase(pc, $urandom_range(1, KCL_MAX_CLUSTER_COUNT), dc,
						$urandom_range(0, 3) == 0 ? $urandom_range(1, 40) :
						$urandom_range(1, 6), 1, $urandom_range(30, 60));
				end
			endcase
			ph++;
		end

		drain();
		repeat (50) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// File: filelist.f
sv/kcl_pkg.sv
sv/kcl_if.sv
sv/kcl_cell.sv
sv/kcl_div.sv
sv/kmeans_cluster_engine_unit.sv
tb/kmeans_cluster_engine_unit_checker.sv
tb/kmeans_cluster_engine_unit_tb.sv
